### sv/polygon_fan_triangulator_defines.svh
// Assertion macros for the top-level file, the only file that carries checks.
`ifndef POLYGON_FAN_TRIANGULATOR_DEFINES_SVH
`define POLYGON_FAN_TRIANGULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define PFT_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define PFT_ASSERT(lbl, prop, msg) `PFT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define PFT_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define PFT_ASSERT(lbl, prop, msg)
`endif

`endif

### sv/pft_pkg.sv
package pft_pkg;

  localparam int MAX_FACE_VERTICES_DEF = 16;
  localparam int COORD_W = 24;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NORM_W = 51;
  localparam int TRI_VERTS = 3;
  localparam int QUAD_VERTS = 4;

  typedef logic [2:0][COORD_W-1:0] vtx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_DIV,
    S_RDA,
    S_RDB,
    S_RDC,
    S_LDC,
    S_DIFF,
    S_MUL,
    S_NORM,
    S_EM0,
    S_EM1,
    S_EM2
  } state_t;

  typedef enum logic [1:0] {
    VSEL_A,
    VSEL_B,
    VSEL_C
  } vsel_t;

  typedef struct packed {
    logic  clr_face;
    logic  div_go;
    logic  ld_a;
    logic  ld_b;
    logic  ld_c;
    logic  c_cent;
    logic  diff_en;
    logic  mul_en;
    logic  norm_en;
    logic  emit;
    vsel_t emit_sel;
    logic  run_last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

### sv/pft_div.sv
module pft_div #(
  parameter int SUM_W = 29,
  parameter int CW = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic signed [SUM_W-1:0] sum_in [3],
  input  logic [CW-1:0]          n_in,
  output logic                   busy,
  output pft_pkg::vtx_t          quot
);
  import pft_pkg::*;

  localparam int CNTW = $clog2(SUM_W + 1);

  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]    n_r;
  logic [SUM_W-1:0] d_r [3];
  logic [SUM_W-1:0] d_nxt [3];
  logic [CW-1:0]    rem_r [3];
  logic [CW-1:0]    rem_nxt [3];
  logic             neg_r [3];
  logic [CW:0]      trial [3];
  logic             ge [3];

  assign busy = (cnt_r != '0);

  // One quotient bit per lane per cycle, restoring on the magnitude.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_r[k], d_r[k][SUM_W-1]};
      ge[k] = (trial[k] >= {1'b0, n_r});
      rem_nxt[k] = ge[k] ? CW'(trial[k] - {1'b0, n_r}) : CW'(trial[k]);
      d_nxt[k] = {d_r[k][SUM_W-2:0], ge[k]};
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (go) begin
      cnt_nxt = CNTW'(SUM_W);
    end else if (busy) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n_r <= n_in;
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= sum_in[k][SUM_W-1];
        d_r[k] <= sum_in[k][SUM_W-1] ? SUM_W'(-sum_in[k]) : SUM_W'(sum_in[k]);
        rem_r[k] <= '0;
      end
    end else if (busy) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k] <= d_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot[k] = neg_r[k] ? COORD_W'(-d_r[k]) : COORD_W'(d_r[k]);
    end
  end

endmodule

### sv/pft_dpath.sv
module pft_dpath #(
  parameter int MAX_FACE_VERTICES = pft_pkg::MAX_FACE_VERTICES_DEF,
  parameter int AW = 4,
  parameter int CW = 5,
  parameter int SUM_W = 29
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic signed [pft_pkg::COORD_W-1:0] vx,
  input  logic signed [pft_pkg::COORD_W-1:0] vy,
  input  logic signed [pft_pkg::COORD_W-1:0] vz,
  input  pft_pkg::cmd_t              cmd,
  input  logic [AW-1:0]              rd_addr,
  output pft_pkg::sts_t              sts,
  output logic [CW-1:0]              count,
  output logic signed [pft_pkg::COORD_W-1:0] ox,
  output logic signed [pft_pkg::COORD_W-1:0] oy,
  output logic signed [pft_pkg::COORD_W-1:0] oz,
  output logic signed [pft_pkg::NORM_W-1:0]  nx,
  output logic signed [pft_pkg::NORM_W-1:0]  ny,
  output logic signed [pft_pkg::NORM_W-1:0]  nz
);
  import pft_pkg::*;

  vtx_t mem [MAX_FACE_VERTICES];
  vtx_t rd_r;
  vtx_t a_r, b_r, c_r;
  vtx_t cent;
  vtx_t vin;
  vtx_t sel;

  logic [CW-1:0]           count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [SUM_W-1:0] sum_nxt [3];
  logic                    store_en;

  logic signed [DIFF_W-1:0] u_r [3];
  logic signed [DIFF_W-1:0] w_r [3];
  logic signed [PROD_W-1:0] p_r [6];
  logic signed [NORM_W-1:0] nrm_r [3];

  assign vin = {vz, vy, vx};
  assign count = count_r;
  assign store_en = accept && (count_r < CW'(MAX_FACE_VERTICES));

  pft_div #(.SUM_W(SUM_W), .CW(CW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.div_go),
    .sum_in (sum_r),
    .n_in   (count_r),
    .busy   (sts.div_busy),
    .quot   (cent)
  );

  always_comb begin
    count_nxt = count_r;
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = sum_r[k];
    end
    if (cmd.clr_face) begin
      count_nxt = '0;
      for (int k = 0; k < 3; k++) begin
        sum_nxt[k] = '0;
      end
    end else if (store_en) begin
      count_nxt = count_r + CW'(1);
      for (int k = 0; k < 3; k++) begin
        sum_nxt[k] = sum_r[k] + SUM_W'($signed(vin[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[count_r[AW-1:0]] <= vin;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      a_r <= rd_r;
    end
    if (cmd.ld_b) begin
      b_r <= rd_r;
    end
    if (cmd.ld_c) begin
      c_r <= cmd.c_cent ? cent : rd_r;
    end
    if (cmd.diff_en) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= DIFF_W'($signed(b_r[k])) - DIFF_W'($signed(a_r[k]));
        w_r[k] <= DIFF_W'($signed(c_r[k])) - DIFF_W'($signed(a_r[k]));
      end
    end
    if (cmd.mul_en) begin
      p_r[0] <= u_r[1] * w_r[2];
      p_r[1] <= u_r[2] * w_r[1];
      p_r[2] <= u_r[2] * w_r[0];
      p_r[3] <= u_r[0] * w_r[2];
      p_r[4] <= u_r[0] * w_r[1];
      p_r[5] <= u_r[1] * w_r[0];
    end
    if (cmd.norm_en) begin
      for (int k = 0; k < 3; k++) begin
        nrm_r[k] <= NORM_W'(p_r[2*k]) - NORM_W'(p_r[2*k+1]);
      end
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      VSEL_A:  sel = a_r;
      VSEL_B:  sel = b_r;
      VSEL_C:  sel = c_r;
      default: sel = a_r;
    endcase
  end

  assign ox = $signed(sel[0]);
  assign oy = $signed(sel[1]);
  assign oz = $signed(sel[2]);
  assign nx = nrm_r[0];
  assign ny = nrm_r[1];
  assign nz = nrm_r[2];

endmodule

### sv/pft_ctrl.sv
module pft_ctrl #(
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           face_end,
  input  logic [CW-1:0]  count,
  input  pft_pkg::sts_t  sts,
  output pft_pkg::cmd_t  cmd,
  output logic [AW-1:0]  rd_addr,
  output logic           busy
);
  import pft_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic          fan, quad, last_tri;
  logic [CW-1:0] i_next_wrap;
  logic [AW-1:0] ia, ib, ic;

  assign busy = (state_r != S_IDLE);
  assign fan = (n_r > CW'(QUAD_VERTS));
  assign quad = (n_r == CW'(QUAD_VERTS));
  assign i_next_wrap = ((i_r + CW'(1)) == n_r) ? '0 : i_r + CW'(1);

  always_comb begin
    if (fan) begin
      last_tri = ((i_r + CW'(1)) == n_r);
    end else if (quad) begin
      last_tri = (i_r != '0);
    end else begin
      last_tri = 1'b1;
    end
  end

  // The second quad triangle is (v2, v3, v0); fan triangles take the centroid as c.
  always_comb begin
    if (fan) begin
      ia = i_r[AW-1:0];
      ib = i_next_wrap[AW-1:0];
      ic = '0;
    end else if (quad && (i_r != '0)) begin
      ia = AW'(2);
      ib = AW'(3);
      ic = '0;
    end else begin
      ia = '0;
      ib = AW'(1);
      ic = AW'(2);
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    i_nxt = i_r;
    case (state_r)
      S_IDLE: begin
        if (start && face_end) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        n_nxt = count;
        i_nxt = '0;
        if (count < CW'(TRI_VERTS)) begin
          state_nxt = S_IDLE;
        end else if (count > CW'(QUAD_VERTS)) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_RDA;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_RDC;
      S_RDC:  state_nxt = S_LDC;
      S_LDC:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_NORM;
      S_NORM: state_nxt = S_EM0;
      S_EM0:  state_nxt = S_EM1;
      S_EM1:  state_nxt = S_EM2;
      S_EM2: begin
        if (last_tri) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_RDA;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r <= '0;
      i_r <= '0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      i_r <= i_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.emit_sel = VSEL_A;
    cmd.c_cent = fan;
    rd_addr = ia;
    case (state_r)
      S_CHK: begin
        cmd.clr_face = 1'b1;
        cmd.div_go = (count > CW'(QUAD_VERTS));
      end
      S_RDB: begin
        rd_addr = ib;
        cmd.ld_a = 1'b1;
      end
      S_RDC: begin
        rd_addr = ic;
        cmd.ld_b = 1'b1;
      end
      S_LDC:  cmd.ld_c = 1'b1;
      S_DIFF: cmd.diff_en = 1'b1;
      S_MUL:  cmd.mul_en = 1'b1;
      S_NORM: cmd.norm_en = 1'b1;
      S_EM0: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = VSEL_A;
      end
      S_EM1: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = VSEL_B;
      end
      S_EM2: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = VSEL_C;
        cmd.run_last = last_tri;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

endmodule

### sv/polygon_fan_triangulator.sv
// Channel   Handshake              Payload
// input     start, busy            in_vertex_x/y/z, in_face_end
// result    out_valid (strobe)     out_x/y/z, out_normal_x/y/z, out_run_last
//
// A vertex without the face end mark is taken while the block is idle; start may stay high.
// A closing beat is followed by a check state, then for five or more vertices by a centroid
// division of one quotient bit per cycle, then per triangle by three store reads, operand
// load, difference, multiply, normal and three beats.
// Reset (synchronous, rst_n low) clears the face count and sums, not the vertex store.
// Results cannot be stalled: each beat is shown for one cycle.
`include "polygon_fan_triangulator_defines.svh"

module polygon_fan_triangulator #(
  parameter int MAX_FACE_VERTICES = pft_pkg::MAX_FACE_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [pft_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [pft_pkg::COORD_W-1:0] in_vertex_y,
  input  logic signed [pft_pkg::COORD_W-1:0] in_vertex_z,
  input  logic in_face_end,
  output logic out_valid,
  output logic signed [pft_pkg::COORD_W-1:0] out_x,
  output logic signed [pft_pkg::COORD_W-1:0] out_y,
  output logic signed [pft_pkg::COORD_W-1:0] out_z,
  output logic signed [pft_pkg::NORM_W-1:0]  out_normal_x,
  output logic signed [pft_pkg::NORM_W-1:0]  out_normal_y,
  output logic signed [pft_pkg::NORM_W-1:0]  out_normal_z,
  output logic out_run_last
);
  import pft_pkg::*;

  localparam int AW = $clog2(MAX_FACE_VERTICES);
  localparam int CW = $clog2(MAX_FACE_VERTICES + 1);
  localparam int SUM_W = COORD_W + CW;

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_addr;
  logic          accept;

  assign accept = start && !busy;
  assign out_valid = cmd.emit;
  assign out_run_last = cmd.run_last;

  pft_ctrl #(.AW(AW), .CW(CW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .face_end (in_face_end),
    .count    (count),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .busy     (busy)
  );

  pft_dpath #(
    .MAX_FACE_VERTICES (MAX_FACE_VERTICES),
    .AW                (AW),
    .CW                (CW),
    .SUM_W             (SUM_W)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .vx      (in_vertex_x),
    .vy      (in_vertex_y),
    .vz      (in_vertex_z),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .sts     (sts),
    .count   (count),
    .ox      (out_x),
    .oy      (out_y),
    .oz      (out_z),
    .nx      (out_normal_x),
    .ny      (out_normal_y),
    .nz      (out_normal_z)
  );

  `PFT_ASSERT(a_beat_when_busy, out_valid |-> busy, "result beat outside a face closing")
  `PFT_ASSERT(a_last_has_beat, out_run_last |-> out_valid, "run_last without a result beat")
  `PFT_ASSERT(a_open_stays_idle, (start && !busy && !in_face_end) |=> !busy, "busy after a plain vertex")
  `PFT_ASSERT(a_close_goes_busy, (start && !busy && in_face_end) |=> busy, "closing beat did not start emission")

endmodule
